/* hw/rtl/abhb_pkg.sv */
// Shared types and constants for the axis homing / backlash sequencer.
// No dependencies; imported by abhb_step and axis_homing_backlash_fsm.
package abhb_pkg;

  localparam int POS_W = 32;
  localparam int OS_W  = 16;
  localparam int PH_W  = 3;

  // Homing stages, in sequence order
  localparam logic [PH_W-1:0] PH_LEAVE   = 3'd0;  // drive up off the home switch
  localparam logic [PH_W-1:0] PH_OVER_UP = 3'd1;  // overshoot up past the release point
  localparam logic [PH_W-1:0] PH_RETURN  = 3'd2;  // drive down back onto the switch
  localparam logic [PH_W-1:0] PH_OVER_DN = 3'd3;  // overshoot down past the trigger point
  localparam logic [PH_W-1:0] PH_RELEASE = 3'd4;  // drive up until the switch releases
  localparam logic [PH_W-1:0] PH_TOUCH   = 3'd5;  // drive down until the switch triggers
  localparam logic [PH_W-1:0] PH_DONE    = 3'd6;  // finished, holds homed

  // Configuration register indexes
  localparam logic CFG_OVER_UP = 1'b0;
  localparam logic CFG_OVER_DN = 1'b1;

  localparam logic [OS_W-1:0] OVER_UP_RST = 16'd50;
  localparam logic [OS_W-1:0] OVER_DN_RST = 16'd10;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [PH_W-1:0] phase;
    pos_t            ref_pos;
    pos_t            backlash;
  } axis_state_t;

endpackage

/* hw/rtl/abhb_step.sv */
// Next-state logic for one tick of the homing sequence, including the
// fall-through between stages. Purely combinational; depends on abhb_pkg.
module abhb_step (
  input  abhb_pkg::axis_state_t       state_cur,
  input  logic [abhb_pkg::OS_W-1:0]   overshoot_up,
  input  logic [abhb_pkg::OS_W-1:0]   overshoot_down,
  input  logic                        restart,
  input  abhb_pkg::pos_t              position,
  input  logic                        home_switch,
  input  logic                        far_switch,
  output abhb_pkg::axis_state_t       state_nxt,
  output logic                        move_down
);
  import abhb_pkg::*;

  logic signed [POS_W+1:0] pos_x;
  logic signed [POS_W+1:0] ref_x;
  logic signed [POS_W+1:0] up_lim;
  logic signed [POS_W+1:0] dn_lim;
  logic signed [POS_W:0]   rel_diff;
  logic signed [POS_W:0]   ret_diff;
  pos_t                    rel_sat;
  pos_t                    ret_sat;
  logic                    past_up;
  logic                    past_dn;

  function automatic pos_t sat_pos(input logic signed [POS_W:0] v);
    pos_t r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Compares run two bits wider than the position so they never wrap
  assign pos_x    = {{2{position[POS_W-1]}}, position};
  assign ref_x    = {{2{state_cur.ref_pos[POS_W-1]}}, state_cur.ref_pos};
  assign up_lim   = ref_x + {{(POS_W+2-OS_W){1'b0}}, overshoot_up};
  assign dn_lim   = ref_x - {{(POS_W+2-OS_W){1'b0}}, overshoot_down};
  assign past_up  = pos_x > up_lim;
  assign past_dn  = pos_x < dn_lim;

  assign rel_diff = {position[POS_W-1], position}
                  - {state_cur.ref_pos[POS_W-1], state_cur.ref_pos};
  assign ret_diff = {state_cur.ref_pos[POS_W-1], state_cur.ref_pos}
                  - {position[POS_W-1], position};
  assign rel_sat  = sat_pos(rel_diff);
  assign ret_sat  = sat_pos(ret_diff);

  // A stage entered during this tick sets ref_pos to the current position,
  // so its own overshoot compare cannot pass in the same tick: chains stop
  // at the overshoot-down stage and at the touch stage.
  always_comb begin
    state_nxt = state_cur;
    move_down = 1'b1;
    if (restart) begin
      state_nxt.phase    = PH_LEAVE;
      state_nxt.backlash = '0;
      state_nxt.ref_pos  = position;
      move_down          = 1'b0;
    end else begin
      unique case (state_cur.phase)
        PH_LEAVE: begin
          move_down = 1'b0;
          if (!home_switch || far_switch) begin
            state_nxt.ref_pos = position;
            state_nxt.phase   = PH_OVER_UP;
            if (far_switch) begin
              state_nxt.phase = PH_RETURN;
              move_down       = 1'b1;
              if (home_switch) begin
                state_nxt.phase = PH_OVER_DN;
              end
            end
          end
        end
        PH_OVER_UP: begin
          move_down = 1'b0;
          if (past_up || far_switch) begin
            state_nxt.ref_pos = position;
            state_nxt.phase   = PH_RETURN;
            move_down         = 1'b1;
            if (home_switch) begin
              state_nxt.phase = PH_OVER_DN;
            end
          end
        end
        PH_RETURN: begin
          if (home_switch) begin
            state_nxt.ref_pos = position;
            state_nxt.phase   = PH_OVER_DN;
          end
        end
        PH_OVER_DN: begin
          if (past_dn) begin
            state_nxt.ref_pos = position;
            state_nxt.phase   = PH_RELEASE;
            move_down         = 1'b0;
            if (!home_switch) begin
              // released at the turn point: zero distance
              state_nxt.backlash = '0;
              state_nxt.phase    = PH_TOUCH;
              move_down          = 1'b1;
            end
          end
        end
        PH_RELEASE: begin
          move_down = 1'b0;
          if (!home_switch) begin
            state_nxt.backlash = rel_sat;
            state_nxt.ref_pos  = position;
            state_nxt.phase    = PH_TOUCH;
            move_down          = 1'b1;
          end
        end
        PH_TOUCH: begin
          if (home_switch) begin
            if ($signed(ret_sat) > $signed(state_cur.backlash)) begin
              state_nxt.backlash = ret_sat;
            end
            state_nxt.phase = PH_DONE;
          end
        end
        default: begin
          // finished, and the unused code: hold everything, drive down
        end
      endcase
    end
  end

endmodule

/* hw/rtl/axis_homing_backlash_fsm.sv */
// Top level of the stepper homing sequencer with backlash measurement.
// Depends on abhb_pkg and abhb_step.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in_     | sink      | in_tvalid/in_tready  | tdata: position, home_switch, far_switch
//          |           |                      | tuser: restart
//  out_    | source    | out_tvalid/out_tready| tdata: move_down, homed, backlash, phase
//  cfg_    | sink      | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// Flow: one transaction per clock sustained while out_tready is high; each input transaction
//   passes through the input register, then the step logic into the result register.
// The rate is set by the combinational step logic that closes the homing state loop.
// Reset (rst_n low, synchronous): stage 0, reference and backlash zero, overshoots
//   back to 50 and 10, both pipeline registers empty.
// Stalls: a held result stalls the input register only when that register is full.
module axis_homing_backlash_fsm (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] position, [32] home_switch, [33] far_switch
  input  logic        in_tuser,   // [0] restart
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] move_down, [1] homed, [33:2] backlash, [36:34] phase
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import abhb_pkg::*;

  // configuration
  logic [OS_W-1:0] over_up_r;
  logic [OS_W-1:0] over_dn_r;

  // input register
  logic            in_valid_r;
  logic            in_restart_r;
  pos_t            in_pos_r;
  logic            in_home_r;
  logic            in_far_r;

  // homing state
  axis_state_t     state_r;
  axis_state_t     state_nxt;
  logic            move_down_nxt;

  // result register
  logic            out_valid_r;
  logic            out_move_down_r;
  logic            out_homed_r;
  pos_t            out_backlash_r;
  logic [PH_W-1:0] out_phase_r;

  logic            advance;

  // Advance the input register into the result register when the result slot
  // is empty or being emptied this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  abhb_step u_step (
    .state_cur      (state_r),
    .overshoot_up   (over_up_r),
    .overshoot_down (over_dn_r),
    .restart        (in_restart_r),
    .position       (in_pos_r),
    .home_switch    (in_home_r),
    .far_switch     (in_far_r),
    .state_nxt      (state_nxt),
    .move_down      (move_down_nxt)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      over_up_r <= OVER_UP_RST;
      over_dn_r <= OVER_DN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OVER_UP: over_up_r <= cfg_data;
        CFG_OVER_DN: over_dn_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // control: valid flags and homing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: capture the input transaction, then the result
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_restart_r <= in_tuser;
      in_pos_r     <= in_tdata[31:0];
      in_home_r    <= in_tdata[32];
      in_far_r     <= in_tdata[33];
    end
    if (advance) begin
      out_move_down_r <= move_down_nxt;
      out_homed_r     <= (state_nxt.phase >= PH_DONE);
      out_backlash_r  <= state_nxt.backlash;
      out_phase_r     <= state_nxt.phase;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_phase_r, out_backlash_r, out_homed_r, out_move_down_r};

endmodule
